/* rtl/core/dxt_pkg.sv */
// shared constants, types and arithmetic helpers for the dxt block texel decoder
`timescale 1ns / 1ps

package dxt_pkg;

    localparam int unsigned MAX_BLOCK_ROWS   = 1024;
    localparam int unsigned WIDTH_MAX_BLOCKS = 1024;
    localparam int unsigned DXT_QUEUE_DEPTH  = 2;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE = 2'd0,
        CFG_IMAGE_WIDTH = 2'd1
    } t_cfg_idx;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] t_rgb;

    // one decoded block as it travels from the front to the back
    typedef struct packed {
        logic [3:0][23:0] rgb;
        logic             trans3;
        logic [7:0][7:0]  apal;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
        logic [9:0]       col;
        logic [9:0]       row;
    } t_block;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        block_done;
    } t_texel;

    function automatic t_rgb expand565(input logic [15:0] v);
        t_rgb e;
        e[2] = {v[15:11], v[15:13]};
        e[1] = {v[10:5], v[10:9]};
        e[0] = {v[4:0], v[4:2]};
        return e;
    endfunction

    // x / 3 for x up to 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    // x / 7 for x up to 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return p[21:14];
    endfunction

    // x / 5 for x up to 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd1639;
        return p[20:13];
    endfunction

endpackage

/* rtl/core/dxt_if.sv */
// valid/ready channel interfaces for blocks, texels and configuration writes
`timescale 1ns / 1ps

interface dxt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] color_block;
    logic [63:0] alpha_block;
    logic        start_of_image;

    modport source (output valid, color_block, alpha_block, start_of_image, input ready);
    modport sink   (input valid, color_block, alpha_block, start_of_image, output ready);
endinterface

interface dxt_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        block_done;

    modport source (output valid, red, green, blue, alpha, pixel_x, pixel_y, block_done,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, pixel_x, pixel_y, block_done,
                    output ready);
endinterface

interface dxt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dxt_pkg::CFG_IDX_W-1:0]   index;
    logic [dxt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/dxt_front.sv */
// front end: block intake, position tracking and palette construction
`timescale 1ns / 1ps

module dxt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dxt_in_if.sink          i_blk,
    input  logic [10:0]     i_width_blocks,
    input  logic            i_full,
    output logic            o_push,
    output dxt_pkg::t_block o_entry
);
    import dxt_pkg::*;

    typedef struct packed {
        t_rgb             e0;
        t_rgb             e1;
        logic             c_gt;
        logic [2:0][9:0]  n_2ab;
        logic [2:0][9:0]  n_a2b;
        logic [2:0][9:0]  n_ab;
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic             a_gt;
        logic [5:0][10:0] n7;
        logic [3:0][10:0] n5;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
        logic [9:0]       col;
        logic [9:0]       row;
    } t_num;

    logic        r_s1_valid;
    t_num        r_s1;
    t_num        n_s1;
    logic [9:0]  r_col;
    logic [9:0]  r_row;
    logic [9:0]  n_col;
    logic [9:0]  n_row;
    logic        accept;
    logic [9:0]  col_use;
    logic [9:0]  row_use;
    logic [10:0] w_eff;
    logic [10:0] col_inc;
    logic [10:0] row_inc;

    assign i_blk.ready = !r_s1_valid || !i_full;
    assign accept      = i_blk.valid && i_blk.ready;
    assign o_push      = r_s1_valid && !i_full;

    // block position
    always_comb begin
        col_use = i_blk.start_of_image ? 10'd0 : r_col;
        row_use = i_blk.start_of_image ? 10'd0 : r_row;
        if (i_width_blocks == 11'd0) begin
            w_eff = 11'd1;
        end else if (i_width_blocks > 11'(WIDTH_MAX_BLOCKS)) begin
            w_eff = 11'(WIDTH_MAX_BLOCKS);
        end else begin
            w_eff = i_width_blocks;
        end
        col_inc = {1'b0, col_use} + 11'd1;
        row_inc = {1'b0, row_use} + 11'd1;
        if (col_inc >= w_eff) begin
            n_col = 10'd0;
            n_row = (13'(row_inc) >= 13'(MAX_BLOCK_ROWS)) ? 10'd0 : row_inc[9:0];
        end else begin
            n_col = col_inc[9:0];
            n_row = row_use;
        end
    end

    // endpoint expansion and interpolation numerators
    always_comb begin
        n_s1.e0    = expand565(i_blk.color_block[15:0]);
        n_s1.e1    = expand565(i_blk.color_block[31:16]);
        n_s1.c_gt  = i_blk.color_block[15:0] > i_blk.color_block[31:16];
        for (int ch = 0; ch < 3; ch++) begin
            n_s1.n_2ab[ch] = {1'b0, n_s1.e0[ch], 1'b0} + 10'(n_s1.e1[ch]);
            n_s1.n_a2b[ch] = 10'(n_s1.e0[ch]) + {1'b0, n_s1.e1[ch], 1'b0};
            n_s1.n_ab[ch]  = 10'(n_s1.e0[ch]) + 10'(n_s1.e1[ch]);
        end
        n_s1.a0   = i_blk.alpha_block[7:0];
        n_s1.a1   = i_blk.alpha_block[15:8];
        n_s1.a_gt = n_s1.a0 > n_s1.a1;
        for (int k = 1; k <= 6; k++) begin
            n_s1.n7[k-1] = 11'(11'(n_s1.a0) * 11'(7 - k) + 11'(n_s1.a1) * 11'(k));
        end
        for (int k = 1; k <= 4; k++) begin
            n_s1.n5[k-1] = 11'(11'(n_s1.a0) * 11'(5 - k) + 11'(n_s1.a1) * 11'(k));
        end
        n_s1.cidx = i_blk.color_block[63:32];
        n_s1.aidx = i_blk.alpha_block[63:16];
        n_s1.col  = col_use;
        n_s1.row  = row_use;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= 10'd0;
            r_row      <= 10'd0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !o_push);
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // palette division by reciprocal multiply
    always_comb begin
        o_entry.rgb[0] = r_s1.e0;
        o_entry.rgb[1] = r_s1.e1;
        for (int ch = 0; ch < 3; ch++) begin
            if (r_s1.c_gt) begin
                o_entry.rgb[2][ch*8 +: 8] = div3(r_s1.n_2ab[ch]);
                o_entry.rgb[3][ch*8 +: 8] = div3(r_s1.n_a2b[ch]);
            end else begin
                o_entry.rgb[2][ch*8 +: 8] = r_s1.n_ab[ch][8:1];
                o_entry.rgb[3][ch*8 +: 8] = 8'd0;
            end
        end
        o_entry.trans3  = !r_s1.c_gt;
        o_entry.apal[0] = r_s1.a0;
        o_entry.apal[1] = r_s1.a1;
        if (r_s1.a_gt) begin
            for (int k = 1; k <= 6; k++) begin
                o_entry.apal[k+1] = div7(r_s1.n7[k-1]);
            end
        end else begin
            for (int k = 1; k <= 4; k++) begin
                o_entry.apal[k+1] = div5(r_s1.n5[k-1]);
            end
            o_entry.apal[6] = 8'd0;
            o_entry.apal[7] = 8'hFF;
        end
        o_entry.cidx = r_s1.cidx;
        o_entry.aidx = r_s1.aidx;
        o_entry.col  = r_s1.col;
        o_entry.row  = r_s1.row;
    end

endmodule

/* rtl/core/dxt_queue.sv */
// small block queue between front and back
`timescale 1ns / 1ps

module dxt_queue #(
    parameter int unsigned DEPTH = dxt_pkg::DXT_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dxt_pkg::t_block i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dxt_pkg::t_block o_entry
);
    import dxt_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_block           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

/* rtl/core/dxt_back.sv */
// back end: sixteen-texel sequencer with output register
`timescale 1ns / 1ps

module dxt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_format_mode,
    input  logic            i_q_valid,
    input  dxt_pkg::t_block i_q_entry,
    output logic            o_pop,
    dxt_out_if.source       o_texel
);
    import dxt_pkg::*;

    t_block     r_blk;
    logic       r_busy;
    logic [3:0] r_idx;
    logic       r_out_valid;
    t_texel     r_tex;
    t_texel     n_tex;
    logic       out_load;
    logic       emit;
    logic       last;
    logic [1:0] ci;
    logic [2:0] ai;
    logic [5:0] a_pos;

    assign out_load = !r_out_valid || o_texel.ready;
    assign emit     = r_busy && out_load;
    assign last     = r_idx == 4'd15;
    assign o_pop    = i_q_valid && (!r_busy || (emit && last));

    always_comb begin
        ci    = r_blk.cidx[{r_idx, 1'b0} +: 2];
        a_pos = 6'({r_idx, 1'b0}) + 6'(r_idx);
        ai    = r_blk.aidx[a_pos +: 3];
        n_tex.red   = r_blk.rgb[ci][23:16];
        n_tex.green = r_blk.rgb[ci][15:8];
        n_tex.blue  = r_blk.rgb[ci][7:0];
        if (i_format_mode) begin
            n_tex.alpha = r_blk.apal[ai];
        end else begin
            n_tex.alpha = (ci == 2'd3 && r_blk.trans3) ? 8'd0 : 8'hFF;
        end
        n_tex.pixel_x    = {r_blk.col, r_idx[1:0]};
        n_tex.pixel_y    = {r_blk.row, r_idx[3:2]};
        n_tex.block_done = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end else if (emit) begin
                r_busy <= !last;
                r_idx  <= r_idx + 4'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_texel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_blk <= i_q_entry;
        end
        if (emit) begin
            r_tex <= n_tex;
        end
    end

    assign o_texel.valid      = r_out_valid;
    assign o_texel.red        = r_tex.red;
    assign o_texel.green      = r_tex.green;
    assign o_texel.blue       = r_tex.blue;
    assign o_texel.alpha      = r_tex.alpha;
    assign o_texel.pixel_x    = r_tex.pixel_x;
    assign o_texel.pixel_y    = r_tex.pixel_y;
    assign o_texel.block_done = r_tex.block_done;

endmodule

/* rtl/core/dxt_block_texel_decoder.sv */
// top level of the dxt1/dxt5 block texel decoder
//
//  channel   dir  payload                                        transfer when
//  i_cfg     in   index, data (format_mode, image_width_blocks)  valid & ready
//  i_blk     in   color_block, alpha_block, start_of_image       valid & ready
//  o_texel   out  red, green, blue, alpha, pixel_x, pixel_y,     valid & ready
//                 block_done
//
//  each block yields 16 texels at one texel per cycle while the output is not
//  stalled; the back end texel sequencer produces them
//  a block flows through the front register, queue, r_blk and texel register
//  synchronous active-low reset; format_mode resets to dxt1, width to 1 block
//  an output stall holds the texel register, the queue fills and i_blk.ready drops
`timescale 1ns / 1ps

module dxt_block_texel_decoder #(
    parameter int unsigned QUEUE_DEPTH = dxt_pkg::DXT_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dxt_cfg_if.sink   i_cfg,
    dxt_in_if.sink    i_blk,
    dxt_out_if.source o_texel
);
    import dxt_pkg::*;

    logic        r_format_mode;
    logic [10:0] r_width_blocks;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_block      q_in;
    t_block      q_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode  <= 1'b0;
            r_width_blocks <= 11'd1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FORMAT_MODE: begin
                    r_format_mode <= i_cfg.data[0];
                end
                CFG_IMAGE_WIDTH: begin
                    r_width_blocks <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    dxt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_blk          (i_blk),
        .i_width_blocks (r_width_blocks),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_entry        (q_in)
    );

    dxt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    dxt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_format_mode (r_format_mode),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_out),
        .o_pop         (q_pop),
        .o_texel       (o_texel)
    );

endmodule

/* rtl/core/dxt_chk.sv */
// port-level checks on the texel output of the decoder, bound to the top level
`timescale 1ns / 1ps

module dxt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_tex_valid,
    input logic        i_tex_ready,
    input logic [7:0]  i_red,
    input logic [7:0]  i_green,
    input logic [7:0]  i_blue,
    input logic [7:0]  i_alpha,
    input logic [11:0] i_pixel_x,
    input logic [11:0] i_pixel_y,
    input logic        i_block_done
);

    // stalled texel stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tex_valid && !i_tex_ready |=> i_tex_valid &&
        $stable({i_red, i_green, i_blue, i_alpha, i_pixel_x, i_pixel_y, i_block_done}))
        else $error("texel changed while stalled");

    // last texel sits at the block's bottom-right corner
    a_done_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tex_valid && i_block_done |-> i_pixel_x[1:0] == 2'd3 && i_pixel_y[1:0] == 2'd3)
        else $error("block_done off the block corner");

    // a block's texels come without gaps
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tex_valid && i_tex_ready && !i_block_done |=> i_tex_valid)
        else $error("gap inside a block");

    // raster order inside a row of the block
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tex_valid && i_tex_ready && !i_block_done && i_pixel_x[1:0] != 2'd3 |=>
        i_pixel_x == 12'($past(i_pixel_x) + 12'd1) && i_pixel_y == $past(i_pixel_y))
        else $error("texel column did not advance");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_tex_valid)
        else $error("texel valid after reset");

endmodule

bind dxt_block_texel_decoder dxt_chk u_dxt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tex_valid  (o_texel.valid),
    .i_tex_ready  (o_texel.ready),
    .i_red        (o_texel.red),
    .i_green      (o_texel.green),
    .i_blue       (o_texel.blue),
    .i_alpha      (o_texel.alpha),
    .i_pixel_x    (o_texel.pixel_x),
    .i_pixel_y    (o_texel.pixel_y),
    .i_block_done (o_texel.block_done)
);
